@@ design/spce_pkg.sv @@
package spce_pkg;

    // segment byte positions in the display image
    localparam logic [3:0] B_SPD_HUN  = 4'd0;
    localparam logic [3:0] B_SPD_TEN  = 4'd1;
    localparam logic [3:0] B_SPD_UNIT = 4'd2;
    localparam logic [3:0] B_HDG_HUN  = 4'd3;
    localparam logic [3:0] B_HDG_TEN  = 4'd4;
    localparam logic [3:0] B_HDG_UNIT = 4'd5;
    localparam logic [3:0] B_ALT_TTH  = 4'd6;
    localparam logic [3:0] B_ALT_THO  = 4'd7;
    localparam logic [3:0] B_ALT_HUN  = 4'd8;
    localparam logic [3:0] B_ALT_TEN  = 4'd9;
    localparam logic [3:0] B_ALT_UNIT = 4'd10;
    localparam logic [3:0] B_VRT_THO  = 4'd11;
    localparam logic [3:0] B_VRT_HUN  = 4'd12;
    localparam logic [3:0] B_VRT_TEN  = 4'd13;
    localparam logic [3:0] B_VRT_UNIT = 4'd14;
    localparam logic [3:0] B_LABELS   = 4'd15;

    localparam int IMAGE_DEPTH = 16;

    // command codes
    localparam logic [3:0] ACT_SPD      = 4'd0;
    localparam logic [3:0] ACT_MACH     = 4'd1;
    localparam logic [3:0] ACT_HDG      = 4'd2;
    localparam logic [3:0] ACT_ALT      = 4'd3;
    localparam logic [3:0] ACT_VS       = 4'd4;
    localparam logic [3:0] ACT_FPA      = 4'd5;
    localparam logic [3:0] ACT_DASH_SPD = 4'd6;
    localparam logic [3:0] ACT_DASH_HDG = 4'd7;
    localparam logic [3:0] ACT_DASH_ALT = 4'd8;
    localparam logic [3:0] ACT_DASH_VS  = 4'd9;
    localparam logic [3:0] ACT_DOT_SPD  = 4'd10;
    localparam logic [3:0] ACT_DOT_HDG  = 4'd11;
    localparam logic [3:0] ACT_DOT_ALT  = 4'd12;
    localparam logic [3:0] ACT_TRK      = 4'd13;

    // pattern codes beyond the decimal digits
    localparam logic [3:0] PAT_DASH   = 4'd10;
    localparam logic [3:0] PAT_BLANK  = 4'd11;
    localparam logic [3:0] PAT_SMALL0 = 4'd12;

    // program of byte updates per command
    localparam int PROG_LEN = 5;
    localparam int CNT_W    = $clog2(PROG_LEN + 1);
    localparam int STEP_W   = $clog2(PROG_LEN);

    // decimal digit extraction
    localparam int DIGITS   = 5;
    localparam int DIG_CW   = $clog2(DIGITS + 1);
    localparam int DIG_IW   = $clog2(DIGITS);
    localparam int VAL_W    = 17;
    localparam int RECIP_SH = 24;
    localparam int RECIP_W  = 21;
    localparam logic [RECIP_W-1:0] RECIP10 = RECIP_W'(((1 << RECIP_SH) + 9) / 10);
    localparam int QUO_W    = VAL_W + RECIP_W - RECIP_SH;

    // queue depths
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic [3:0] idx;
        logic [7:0] mask;
        logic [7:0] val;
        logic       emit;
    } step_t;

    typedef struct packed {
        step_t [PROG_LEN-1:0] steps;
        logic  [CNT_W-1:0]    cnt;
    } prog_t;

    typedef struct packed {
        logic [4:0] addr;
        logic [7:0] data;
        logic       last;
    } lcd_wr_t;

    // 7-segment pattern for a digit or symbol code, bit 0 always clear
    function automatic logic [7:0] seg_pat(input logic [3:0] d);
        logic [7:0] p;
        unique case (d)
            4'd0:       p = 8'hFA;
            4'd1:       p = 8'h60;
            4'd2:       p = 8'hBC;
            4'd3:       p = 8'hF4;
            4'd4:       p = 8'h66;
            4'd5:       p = 8'hD6;
            4'd6:       p = 8'hDE;
            4'd7:       p = 8'h70;
            4'd8:       p = 8'hFE;
            4'd9:       p = 8'hF6;
            PAT_DASH:   p = 8'h04;
            PAT_SMALL0: p = 8'hCC;
            default:    p = 8'h00;
        endcase
        return p;
    endfunction

    function automatic step_t mk_step(input logic [3:0] idx, input logic [7:0] mask,
                                      input logic [7:0] val, input logic emit);
        step_t s;
        s.idx  = idx;
        s.mask = mask;
        s.val  = val;
        s.emit = emit;
        return s;
    endfunction

endpackage

@@ design/spce_fifo.sv @@
module spce_fifo import spce_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMD_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_FW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_FW-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == CNT_FW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/spce_front.sv @@
module spce_front import spce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         action,
    input  logic signed [31:0] value,
    input  logic               sign_enable,
    output prog_t              prog,
    output logic               prog_valid,
    input  logic               q_full
);

    logic                    busy_reg, busy_next;
    logic [DIG_CW-1:0]       cnt_reg, cnt_next;
    logic [DIG_CW-1:0]       ndig_reg;
    logic [3:0]              act_reg;
    logic                    on_reg, vs_pos_reg, vs_nz_reg, fpa_nonneg_reg;
    logic [VAL_W-1:0]        v_reg;
    logic [3:0]              dig_reg [DIGITS];

    logic                    accept, done, finish;
    logic [15:0]             u16, mag16;
    logic [7:0]              mag8;
    logic [VAL_W-1:0]        v_in;
    logic [DIG_CW-1:0]       ndig_in;
    logic [VAL_W+RECIP_W-1:0] prod;
    logic [QUO_W-1:0]        quo;
    logic [VAL_W-1:0]        quo_ext, quo10, rem;
    logic                    sp, mach, hdg;
    logic [3:0]              dp;

    // classify and clamp the incoming command
    always_comb
    begin
        u16   = value[15:0];
        mag16 = value[15] ? (~value[15:0] + 16'd1) : value[15:0];
        mag8  = value[7] ? (~value[7:0] + 8'd1) : value[7:0];
        v_in    = '0;
        ndig_in = '0;
        unique case (action) inside
            ACT_SPD, ACT_MACH, ACT_HDG:
            begin
                v_in    = (u16 > 16'd999) ? VAL_W'(999) : VAL_W'(u16);
                ndig_in = DIG_CW'(3);
            end
            ACT_ALT:
            begin
                v_in    = ($unsigned(value) > 32'd99999) ? VAL_W'(99999) : VAL_W'(value);
                ndig_in = DIG_CW'(5);
            end
            ACT_VS:
            begin
                v_in    = (mag16 > 16'd9999) ? VAL_W'(9999) : VAL_W'(mag16);
                ndig_in = DIG_CW'(4);
            end
            ACT_FPA:
            begin
                v_in    = (mag8 > 8'd99) ? VAL_W'(99) : VAL_W'(mag8);
                ndig_in = DIG_CW'(2);
            end
            default:
            begin
                v_in    = '0;
                ndig_in = '0;
            end
        endcase
    end

    // one decimal digit a cycle by reciprocal multiply
    assign prod    = v_reg * RECIP10;
    assign quo     = prod[VAL_W+RECIP_W-1:RECIP_SH];
    assign quo_ext = VAL_W'(quo);
    assign quo10   = (quo_ext << 3) + (quo_ext << 1);
    assign rem     = v_reg - quo10;

    // handshake with the command queue
    assign done       = busy_reg && (cnt_reg == ndig_reg);
    assign prog_valid = done && (prog.cnt != '0);
    assign finish     = done && ((prog.cnt == '0) || !q_full);
    assign full       = busy_reg && !finish;
    assign accept     = push && !full;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && !done)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // command payload and digit registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg        <= action;
            on_reg         <= (value[7:0] != 8'd0);
            vs_pos_reg     <= !value[15] && (u16 != 16'd0);
            vs_nz_reg      <= (u16 != 16'd0);
            fpa_nonneg_reg <= !value[7];
            v_reg          <= v_in;
            ndig_reg       <= ndig_in;
        end
        else if (busy_reg && !done)
        begin
            dig_reg[cnt_reg[DIG_IW-1:0]] <= rem[3:0];
            v_reg                        <= quo_ext;
        end
    end

    // build the byte update program for the command
    always_comb
    begin
        sp   = (act_reg == ACT_SPD);
        mach = (act_reg == ACT_MACH);
        hdg  = !on_reg;
        dp   = on_reg ? PAT_DASH : PAT_BLANK;
        prog = '0;
        unique case (act_reg) inside
            ACT_SPD, ACT_MACH:
            begin
                prog.steps[0] = mk_step(B_LABELS, 8'h80, {sp, 7'b0}, 1'b1);
                prog.steps[1] = mk_step(B_LABELS, 8'h40, {1'b0, mach, 6'b0}, 1'b1);
                prog.steps[2] = mk_step(B_SPD_UNIT, 8'hFE, seg_pat(dig_reg[0]), 1'b1);
                prog.steps[3] = mk_step(B_SPD_TEN, 8'hFF,
                                        seg_pat(dig_reg[1]) | {7'b0, mach}, 1'b1);
                prog.steps[4] = mk_step(B_SPD_HUN, 8'hFE, seg_pat(dig_reg[2]), 1'b1);
                prog.cnt      = CNT_W'(5);
            end
            ACT_HDG:
            begin
                prog.steps[0] = mk_step(B_HDG_UNIT, 8'hFE, seg_pat(dig_reg[0]), 1'b1);
                prog.steps[1] = mk_step(B_HDG_TEN, 8'hFE, seg_pat(dig_reg[1]), 1'b1);
                prog.steps[2] = mk_step(B_HDG_HUN, 8'hFE, seg_pat(dig_reg[2]), 1'b1);
                prog.cnt      = CNT_W'(3);
            end
            ACT_ALT:
            begin
                prog.steps[0] = mk_step(B_ALT_UNIT, 8'hFE, seg_pat(dig_reg[0]), 1'b1);
                prog.steps[1] = mk_step(B_ALT_TEN, 8'hFE, seg_pat(dig_reg[1]), 1'b1);
                prog.steps[2] = mk_step(B_ALT_HUN, 8'hFE, seg_pat(dig_reg[2]), 1'b1);
                prog.steps[3] = mk_step(B_ALT_THO, 8'hFE, seg_pat(dig_reg[3]), 1'b1);
                prog.steps[4] = mk_step(B_ALT_TTH, 8'hFE, seg_pat(dig_reg[4]), 1'b1);
                prog.cnt      = CNT_W'(5);
            end
            ACT_VS:
            begin
                // sign bits ride along with the small zero digits
                prog.steps[0] = mk_step(B_VRT_UNIT, 8'hFF,
                                        seg_pat(PAT_SMALL0) | {7'b0, vs_nz_reg && sign_enable},
                                        1'b1);
                prog.steps[1] = mk_step(B_VRT_TEN, 8'hFF,
                                        seg_pat(PAT_SMALL0) | {7'b0, vs_pos_reg && sign_enable},
                                        1'b1);
                prog.steps[2] = mk_step(B_VRT_HUN, 8'hFF, seg_pat(dig_reg[2]), 1'b1);
                prog.steps[3] = mk_step(B_VRT_THO, 8'hFE, seg_pat(dig_reg[3]), 1'b1);
                prog.cnt      = CNT_W'(4);
            end
            ACT_FPA:
            begin
                prog.steps[0] = mk_step(B_VRT_HUN, 8'hFF, seg_pat(dig_reg[0]) | 8'h01, 1'b1);
                prog.steps[1] = mk_step(B_VRT_THO, 8'hFE, seg_pat(dig_reg[1]), 1'b1);
                prog.steps[2] = mk_step(B_VRT_TEN, 8'hFF,
                                        {7'b0, fpa_nonneg_reg && sign_enable}, 1'b1);
                prog.steps[3] = mk_step(B_VRT_UNIT, 8'hFF, {7'b0, sign_enable}, 1'b1);
                prog.cnt      = CNT_W'(4);
            end
            ACT_DASH_SPD:
            begin
                // mach point cleared without a write, then labels resent
                prog.steps[0] = mk_step(B_SPD_HUN, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[1] = mk_step(B_SPD_TEN, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[2] = mk_step(B_SPD_UNIT, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[3] = mk_step(B_SPD_TEN, 8'h01, 8'h00, 1'b0);
                prog.steps[4] = mk_step(B_LABELS, 8'h00, 8'h00, 1'b1);
                prog.cnt      = CNT_W'(5);
            end
            ACT_DASH_HDG:
            begin
                prog.steps[0] = mk_step(B_HDG_HUN, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[1] = mk_step(B_HDG_TEN, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[2] = mk_step(B_HDG_UNIT, 8'hFE, seg_pat(dp), 1'b1);
                prog.cnt      = CNT_W'(3);
            end
            ACT_DASH_ALT:
            begin
                prog.steps[0] = mk_step(B_ALT_TTH, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[1] = mk_step(B_ALT_THO, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[2] = mk_step(B_ALT_HUN, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[3] = mk_step(B_ALT_TEN, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[4] = mk_step(B_ALT_UNIT, 8'hFE, seg_pat(dp), 1'b1);
                prog.cnt      = CNT_W'(5);
            end
            ACT_DASH_VS:
            begin
                prog.steps[0] = mk_step(B_VRT_THO, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[1] = mk_step(B_VRT_HUN, 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[2] = mk_step(B_VRT_TEN, on_reg ? 8'hFF : 8'hFE, seg_pat(dp), 1'b1);
                prog.steps[3] = mk_step(B_VRT_UNIT, 8'hFF, seg_pat(dp) | {7'b0, on_reg}, 1'b1);
                prog.cnt      = CNT_W'(4);
            end
            ACT_DOT_SPD:
            begin
                prog.steps[0] = mk_step(B_HDG_HUN, 8'h01, {7'b0, on_reg}, 1'b1);
                prog.cnt      = CNT_W'(1);
            end
            ACT_DOT_HDG:
            begin
                prog.steps[0] = mk_step(B_HDG_UNIT, 8'h01, {7'b0, on_reg}, 1'b1);
                prog.cnt      = CNT_W'(1);
            end
            ACT_DOT_ALT:
            begin
                prog.steps[0] = mk_step(B_VRT_THO, 8'h01, {7'b0, on_reg}, 1'b1);
                prog.cnt      = CNT_W'(1);
            end
            ACT_TRK:
            begin
                // label byte updates merged into one write before the last
                prog.steps[0] = mk_step(B_ALT_TEN, 8'h01, {7'b0, hdg}, 1'b1);
                prog.steps[1] = mk_step(B_ALT_HUN, 8'h01, {7'b0, !hdg}, 1'b1);
                prog.steps[2] = mk_step(B_ALT_THO, 8'h01, {7'b0, hdg}, 1'b1);
                prog.steps[3] = mk_step(B_LABELS, 8'h3C,
                                        {2'b0, hdg, !hdg, !hdg, hdg, 2'b0}, 1'b1);
                prog.steps[4] = mk_step(B_ALT_TTH, 8'h01, {7'b0, !hdg}, 1'b1);
                prog.cnt      = CNT_W'(5);
            end
            default:
            begin
                prog = '0;
            end
        endcase
    end

endmodule

@@ design/spce_exec.sv @@
module spce_exec import spce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  prog_t   q_prog,
    input  logic    q_empty,
    output logic    q_pop,
    output lcd_wr_t wr,
    output logic    wr_valid,
    input  logic    out_full
);

    logic              active_reg, active_next;
    logic [STEP_W-1:0] step_reg, step_next;
    prog_t             prog_reg;
    logic [7:0]        image_reg [IMAGE_DEPTH];

    step_t             cur;
    logic [7:0]        old_byte, new_byte;
    logic              adv, last_step, load;

    // current step and its read-modify-write of the image
    assign cur       = prog_reg.steps[step_reg];
    assign old_byte  = image_reg[cur.idx];
    assign new_byte  = (old_byte & ~cur.mask) | (cur.val & cur.mask);
    assign adv       = active_reg && !(cur.emit && out_full);
    assign last_step = (step_reg == STEP_W'(prog_reg.cnt - CNT_W'(1)));
    assign load      = !active_reg || (adv && last_step);
    assign q_pop     = load && !q_empty;

    // lcd write transaction for an emitting step
    assign wr_valid = adv && cur.emit;
    assign wr.addr  = {cur.idx, 1'b0};
    assign wr.data  = new_byte;
    assign wr.last  = last_step;

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        if (load)
        begin
            active_next = !q_empty;
            step_next   = '0;
        end
        else if (adv)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // sequencer and segment image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
            for (int i = 0; i < IMAGE_DEPTH; i++)
            begin
                image_reg[i] <= (i == int'(B_LABELS))  ? 8'h03 :
                                (i == int'(B_HDG_TEN)) ? 8'h01 : 8'h00;
            end
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
            if (adv)
            begin
                image_reg[cur.idx] <= new_byte;
            end
        end
    end

    // program register
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            prog_reg <= q_prog;
        end
    end

endmodule

@@ design/segment_panel_command_engine.sv @@
// Commands: each one's decimal digits (0 to 5) are split one digit a cycle in the front
// divider, and the front takes a new command only as it hands the last one's program on.
// Its byte updates (up to 5) are applied at the image port one update a cycle, held while
// an emitting update meets a full result queue.
// Reset: asynchronous, active low; queues empty, sign_enable cleared, segment image
// zero except the start label bits and bit 0 of the heading tens byte.
module segment_panel_command_engine import spce_pkg::*;
#(
    parameter int CMD_Q_DEPTH = CMD_DEPTH,
    parameter int OUT_Q_DEPTH = OUT_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         action,
    input  logic signed [31:0] value,
    output logic               empty,
    input  logic               pop,
    output logic [4:0]         lcd_address,
    output logic [7:0]         segment_byte,
    output logic               last_write,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data
);

    logic    sign_enable_reg;
    prog_t   front_prog, q_prog;
    logic    front_valid, q_full, q_empty, q_pop;
    lcd_wr_t exec_wr, out_wr;
    logic    exec_valid, out_full;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            sign_enable_reg <= cfg_write_data;
        end
    end

    // command intake and digit split
    spce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .value       (value),
        .sign_enable (sign_enable_reg),
        .prog        (front_prog),
        .prog_valid  (front_valid),
        .q_full      (q_full)
    );

    // program queue between front and back
    spce_fifo #(
        .WIDTH ($bits(prog_t)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_prog),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_prog),
        .empty   (q_empty)
    );

    // image update and write generation
    spce_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_prog   (q_prog),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .wr       (exec_wr),
        .wr_valid (exec_valid),
        .out_full (out_full)
    );

    // result queue
    spce_fifo #(
        .WIDTH ($bits(lcd_wr_t)),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (exec_valid),
        .wr_data (exec_wr),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_wr),
        .empty   (empty)
    );

    assign lcd_address  = out_wr.addr;
    assign segment_byte = out_wr.data;
    assign last_write   = out_wr.last;

endmodule

@@ sim/tb_segment_panel_command_engine.sv @@
module tb_segment_panel_command_engine import spce_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // command codes the block leaves unused
    localparam logic [3:0] ACT_SPARE_A = 4'd14;
    localparam logic [3:0] ACT_SPARE_B = 4'd15;

    // glyphs for digit codes 0..12, code 0 in the low byte
    localparam logic [13*8-1:0] GLYPHS = {
        8'hCC, 8'h00, 8'h04, 8'hF6, 8'hFE, 8'h70, 8'hDE,
        8'hD6, 8'h66, 8'hF4, 8'hBC, 8'h60, 8'hFA
    };

    localparam int RANDOM_PER_PHASE = 88;
    localparam int SETTLE_CYCLES    = 20;

    typedef struct packed {
        logic [3:0]  act;
        logic [31:0] val;
        logic        typed;
        logic        one_write;
        logic [4:0]  addr;
        logic [7:0]  data;
    } command_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [3:0]         action;
    logic signed [31:0] value;
    logic               empty;
    logic               pop;
    logic [4:0]         lcd_address;
    logic [7:0]         segment_byte;
    logic               last_write;
    logic               cfg_write_en;
    logic               cfg_write_data;

    // mirror of the panel image and the sign setting
    logic [7:0] panel_image [16];
    logic       sign_shown;

    lcd_wr_t command_writes [$];
    lcd_wr_t writes_due [$];

    int  mismatches;
    bit  steady;
    int  stall_left;

    // directed commands; typed rows carry their write in the row
    command_row_t command_rows [27] = '{
        '{ACT_DOT_SPD,  32'h0000_0000, 1'b1, 1'b1, 5'd6,  8'h00},
        '{ACT_DOT_SPD,  32'h0000_0001, 1'b1, 1'b1, 5'd6,  8'h01},
        '{ACT_DOT_HDG,  32'h0000_0100, 1'b1, 1'b1, 5'd10, 8'h00},
        '{ACT_DOT_ALT,  32'hFFFF_FFFF, 1'b1, 1'b1, 5'd22, 8'h01},
        '{ACT_SPARE_A,  32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0,  8'h00},
        '{ACT_SPARE_B,  32'h0000_0000, 1'b1, 1'b0, 5'd0,  8'h00},
        '{ACT_SPD,      32'h0000_0000, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_SPD,      32'h0000_FFFF, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_MACH,     32'h7FFF_004E, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_HDG,      32'h0000_03E7, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_HDG,      32'hFFFF_03E8, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_ALT,      32'h0001_869F, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_ALT,      32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_VS,       32'h0000_7FFF, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_VS,       32'hFFFF_D8F1, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_VS,       32'h0000_8000, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_VS,       32'h0000_0000, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_FPA,      32'h0000_007F, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_FPA,      32'hFFFF_FF80, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_FPA,      32'h0000_0000, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_DASH_SPD, 32'h0000_0001, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_DASH_HDG, 32'hFFFF_FF00, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_DASH_ALT, 32'h0000_0080, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_DASH_VS,  32'h0000_0001, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_DASH_VS,  32'h0000_0000, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_TRK,      32'h0000_0001, 1'b0, 1'b0, 5'd0,  8'h00},
        '{ACT_TRK,      32'h0000_0000, 1'b0, 1'b0, 5'd0,  8'h00}
    };

    segment_panel_command_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .action         (action),
        .value          (value),
        .empty          (empty),
        .pop            (pop),
        .lcd_address    (lcd_address),
        .segment_byte   (segment_byte),
        .last_write     (last_write),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // queue one lcd write of the current byte content
    function automatic void note_write(input logic [3:0] idx);
        lcd_wr_t w;
        if (command_writes.size() < 6)
        begin
            w.addr = {idx, 1'b0};
            w.data = panel_image[idx];
            w.last = 1'b0;
            command_writes.push_back(w);
        end
    endfunction

    function automatic void set_seg_bit(input logic [3:0] idx, input int b, input logic on);
        panel_image[idx][b] = on;
    endfunction

    // replace the glyph, keep bit 0, then write the byte out
    function automatic void draw_digit(input logic [3:0] idx, input int code);
        if (code > 12)
            code = PAT_BLANK;
        panel_image[idx] = (panel_image[idx] & 8'h01) | GLYPHS[code*8 +: 8];
        note_write(idx);
    endfunction

    function automatic void draw_three(input logic [3:0] hun, input logic [3:0] ten,
                                       input logic [3:0] unit, input logic [31:0] v);
        if (v > 999)
            v = 999;
        draw_digit(unit, int'(v % 10));
        v = v / 10;
        draw_digit(ten, int'(v % 10));
        draw_digit(hun, int'(v / 10));
    endfunction

    // image update and lcd writes caused by one panel command
    function automatic void panel_command(input logic [3:0] act, input logic [31:0] raw);
        logic [15:0] u16;
        logic        on;
        logic        hdg;
        logic [31:0] v;
        int          s;
        int          a;
        int          code;
        u16 = raw[15:0];
        on = (raw[7:0] != 8'h00);
        command_writes.delete();
        case (act)
            ACT_SPD, ACT_MACH:
            begin
                set_seg_bit(B_LABELS, 7, act == ACT_SPD);
                note_write(B_LABELS);
                set_seg_bit(B_LABELS, 6, act == ACT_MACH);
                set_seg_bit(B_SPD_TEN, 0, act == ACT_MACH);
                note_write(B_LABELS);
                draw_three(B_SPD_HUN, B_SPD_TEN, B_SPD_UNIT, {16'h0000, u16});
            end
            ACT_HDG:
                draw_three(B_HDG_HUN, B_HDG_TEN, B_HDG_UNIT, {16'h0000, u16});
            ACT_ALT:
            begin
                v = (raw > 99999) ? 32'd99999 : raw;
                draw_digit(B_ALT_UNIT, int'(v % 10));
                v = v / 10;
                draw_digit(B_ALT_TEN, int'(v % 10));
                v = v / 10;
                draw_digit(B_ALT_HUN, int'(v % 10));
                v = v / 10;
                draw_digit(B_ALT_THO, int'(v % 10));
                draw_digit(B_ALT_TTH, int'(v / 10));
            end
            ACT_VS:
            begin
                s = $signed(u16);
                if (s > 9999)
                    s = 9999;
                if (s < -9999)
                    s = -9999;
                a = (s < 0) ? -s : s;
                // sign bits change silently and ride on the digit writes
                set_seg_bit(B_VRT_TEN, 0, (s > 0) && sign_shown);
                set_seg_bit(B_VRT_UNIT, 0, (s != 0) && sign_shown);
                set_seg_bit(B_VRT_HUN, 0, 1'b0);
                draw_digit(B_VRT_UNIT, PAT_SMALL0);
                draw_digit(B_VRT_TEN, PAT_SMALL0);
                draw_digit(B_VRT_HUN, (a / 100) % 10);
                draw_digit(B_VRT_THO, a / 1000);
            end
            ACT_FPA:
            begin
                s = $signed(raw[7:0]);
                if (s > 99)
                    s = 99;
                if (s < -99)
                    s = -99;
                a = (s < 0) ? -s : s;
                set_seg_bit(B_VRT_TEN, 0, (s >= 0) && sign_shown);
                set_seg_bit(B_VRT_UNIT, 0, sign_shown);
                set_seg_bit(B_VRT_HUN, 0, 1'b1);
                draw_digit(B_VRT_HUN, a % 10);
                draw_digit(B_VRT_THO, a / 10);
                panel_image[B_VRT_TEN] = panel_image[B_VRT_TEN] & 8'h01;
                panel_image[B_VRT_UNIT] = panel_image[B_VRT_UNIT] & 8'h01;
                note_write(B_VRT_TEN);
                note_write(B_VRT_UNIT);
            end
            ACT_DASH_SPD:
            begin
                code = on ? PAT_DASH : PAT_BLANK;
                draw_digit(B_SPD_HUN, code);
                draw_digit(B_SPD_TEN, code);
                draw_digit(B_SPD_UNIT, code);
                // mach point goes dark without a write of its own byte
                set_seg_bit(B_SPD_TEN, 0, 1'b0);
                note_write(B_LABELS);
            end
            ACT_DASH_HDG:
            begin
                code = on ? PAT_DASH : PAT_BLANK;
                draw_digit(B_HDG_HUN, code);
                draw_digit(B_HDG_TEN, code);
                draw_digit(B_HDG_UNIT, code);
            end
            ACT_DASH_ALT:
            begin
                code = on ? PAT_DASH : PAT_BLANK;
                draw_digit(B_ALT_TTH, code);
                draw_digit(B_ALT_THO, code);
                draw_digit(B_ALT_HUN, code);
                draw_digit(B_ALT_TEN, code);
                draw_digit(B_ALT_UNIT, code);
            end
            ACT_DASH_VS:
            begin
                code = on ? PAT_DASH : PAT_BLANK;
                set_seg_bit(B_VRT_UNIT, 0, on);
                if (on)
                    set_seg_bit(B_VRT_TEN, 0, 1'b0);
                draw_digit(B_VRT_THO, code);
                draw_digit(B_VRT_HUN, code);
                draw_digit(B_VRT_TEN, code);
                draw_digit(B_VRT_UNIT, code);
            end
            ACT_DOT_SPD:
            begin
                set_seg_bit(B_HDG_HUN, 0, on);
                note_write(B_HDG_HUN);
            end
            ACT_DOT_HDG:
            begin
                set_seg_bit(B_HDG_UNIT, 0, on);
                note_write(B_HDG_UNIT);
            end
            ACT_DOT_ALT:
            begin
                set_seg_bit(B_VRT_THO, 0, on);
                note_write(B_VRT_THO);
            end
            ACT_TRK:
            begin
                // label byte writes merged into one carrying its final value
                hdg = !on;
                set_seg_bit(B_LABELS, 5, hdg);
                set_seg_bit(B_ALT_TEN, 0, hdg);
                note_write(B_ALT_TEN);
                set_seg_bit(B_LABELS, 4, !hdg);
                set_seg_bit(B_ALT_HUN, 0, !hdg);
                note_write(B_ALT_HUN);
                set_seg_bit(B_LABELS, 2, hdg);
                set_seg_bit(B_ALT_THO, 0, hdg);
                note_write(B_ALT_THO);
                set_seg_bit(B_LABELS, 3, !hdg);
                set_seg_bit(B_ALT_TTH, 0, !hdg);
                note_write(B_LABELS);
                note_write(B_ALT_TTH);
            end
            default:
            begin
            end
        endcase
        if (command_writes.size() > 0)
            command_writes[command_writes.size() - 1].last = 1'b1;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // value mix per command: zero, raw noise, or near the clamp limits
    function automatic logic [31:0] pick_value(input logic [3:0] act);
        int r;
        int x;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0;
        if (r <= 2)
            return $urandom;
        case (act)
            ACT_SPD, ACT_MACH, ACT_HDG:
                return {16'($urandom), 16'($urandom_range(0, 1100))};
            ACT_ALT:
                return $urandom_range(0, 101000);
            ACT_VS:
            begin
                x = $urandom_range(0, 21000) - 10500;
                return {16'($urandom), x[15:0]};
            end
            ACT_FPA:
            begin
                x = $urandom_range(0, 230) - 115;
                return {24'($urandom), x[7:0]};
            end
            default:
                return {24'($urandom), 8'($urandom_range(0, 1))};
        endcase
    endfunction

    // present one command and hold it until the block takes it
    task automatic issue(input logic [3:0] act, input logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        action <= act;
        value  <= val;
        @(posedge clk);
        while (full)
            @(posedge clk);
        panel_command(act, val);
    endtask

    task automatic wait_idle();
        while (writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_sign(input logic on);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= on;
        @(posedge clk);
        sign_shown = on;
        cfg_write_en <= 1'b0;
    endtask

    task automatic random_phase();
        int         taken;
        logic [3:0] act;
        taken = 0;
        while (taken < RANDOM_PER_PHASE)
        begin
            act = 4'($urandom_range(0, 15));
            issue(act, pick_value(act));
            foreach (command_writes[k])
                writes_due.push_back(command_writes[k]);
            taken++;
        end
        push <= 1'b0;
    endtask

    // result side: compare each lcd write transaction, then maybe stall
    initial
    begin
        lcd_wr_t want;
        pop = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (writes_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no lcd write, actual addr %0d byte %h last %b",
                             $time, lcd_address, segment_byte, last_write);
                end
                else
                begin
                    want = writes_due.pop_front();
                    if (lcd_address !== want.addr)
                    begin
                        mismatches++;
                        $display("%0t: lcd_address expected %0d actual %0d",
                                 $time, want.addr, lcd_address);
                    end
                    if (segment_byte !== want.data)
                    begin
                        mismatches++;
                        $display("%0t: segment_byte expected %h actual %h",
                                 $time, want.data, segment_byte);
                    end
                    if (last_write !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: last_write expected %b actual %b",
                                 $time, want.last, last_write);
                    end
                end
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    // main sequence
    initial
    begin
        lcd_wr_t typed_write;
        push           = 1'b0;
        action         = ACT_SPD;
        value          = 32'sd0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        rst_n          = 1'b0;
        mismatches     = 0;
        steady         = 1'b0;
        sign_shown     = 1'b0;
        foreach (panel_image[k])
            panel_image[k] = 8'h00;
        panel_image[B_LABELS]  = 8'h03;
        panel_image[B_HDG_TEN] = 8'h01;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed commands at reset setting
        foreach (command_rows[i])
        begin
            issue(command_rows[i].act, command_rows[i].val);
            if (command_rows[i].typed)
            begin
                if (command_rows[i].one_write)
                begin
                    typed_write.addr = command_rows[i].addr;
                    typed_write.data = command_rows[i].data;
                    typed_write.last = 1'b1;
                    writes_due.push_back(typed_write);
                end
            end
            else
            begin
                foreach (command_writes[k])
                    writes_due.push_back(command_writes[k]);
            end
        end
        push <= 1'b0;
        wait_idle();

        // random phases across both sign settings, one without idling
        set_sign(1'b1);
        random_phase();
        wait_idle();
        set_sign(1'b0);
        steady = 1'b1;
        random_phase();
        wait_idle();
        steady = 1'b0;
        set_sign(1'b1);
        random_phase();
        wait_idle();
        set_sign(1'b0);
        random_phase();
        wait_idle();

        if (mismatches == 0 && writes_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
